[src/complex_arithmetic_unit_top_macros.svh]
// Assertion macros shared by the checker of the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define CAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cau_pkg.sv]
// Shared types, constants and saturation helper of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int N_FRONT       = 4;
    localparam int N_STEPS       = 32;
    localparam int N_STAGES      = N_FRONT + N_STEPS + 1;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4,
        OP_MAG  = 3'd5,
        OP_SQM  = 3'd6,
        OP_NONE = 3'd7
    } op_t;

    // Item state while it walks through the iteration stages.
    typedef struct packed {
        op_t         op;
        logic        dz;
        logic        sat_re;
        logic        sat_im;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] d;
        logic [63:0] r_re;
        logic [63:0] r_im;
        logic [63:0] src_re;
        logic [63:0] src_im;
        logic [31:0] q_re;
        logic [31:0] q_im;
    } it_t;

    // Sign and magnitude to 32-bit two's complement; bit 32 flags saturation.
    function automatic logic [32:0] pack_mag(input logic neg, input logic [63:0] q);
        logic [32:0] r;
        if (!neg)
        begin
            if (q > {32'd0, POS_MAX})
                r = {1'b1, POS_MAX};
            else
                r = {1'b0, q[31:0]};
        end
        else
        begin
            if (q > {32'd0, NEG_MIN})
                r = {1'b1, NEG_MIN};
            else
                r = {1'b0, 32'd0 - q[31:0]};
        end
        return r;
    endfunction

endpackage

[src/cau_front.sv]
// Front stages: products, sums, magnitudes and setup of the iteration stages.
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          adv,
    input  logic                in_valid,
    input  logic [2:0]          opcode,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output logic [3:0]          v,
    output cau_pkg::it_t        dout
);
    import cau_pkg::*;

    localparam int IBITS = 32 - FRAC_BITS;
    localparam logic signed [32:0] S33_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0] S33_MIN = 33'sh1_8000_0000;

    typedef struct packed {
        op_t                op;
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] p4;
        logic signed [63:0] p5;
        logic signed [32:0] sim_re;
        logic signed [32:0] sim_im;
    } prod_t;

    typedef struct packed {
        op_t                op;
        logic signed [64:0] s_re;
        logic signed [64:0] s_im;
        logic [63:0]        d;
        logic [31:0]        done_re;
        logic [31:0]        done_im;
        logic               done_sat;
    } sum_t;

    typedef struct packed {
        op_t         op;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] m_re;
        logic [63:0] m_im;
        logic [63:0] d;
        logic [31:0] done_re;
        logic [31:0] done_im;
        logic        done_sat;
    } abs_t;

    logic [3:0] v_reg;
    prod_t      s0_reg, s0_next;
    sum_t       s1_reg, s1_next;
    abs_t       s2_reg, s2_next;
    it_t        s3_reg, s3_next;

    op_t                op_in;
    logic               sqr;
    logic signed [31:0] m0b, m1b;
    logic signed [32:0] ext_are, ext_aim, ext_bre, ext_bim;

    // Stage 0: the six products and the simple operations.
    always_comb
    begin
        op_in   = op_t'(opcode);
        sqr     = (op_in == OP_MAG) || (op_in == OP_SQM);
        m0b     = sqr ? a_re : b_re;
        m1b     = sqr ? a_im : b_im;
        ext_are = 33'(a_re);
        ext_aim = 33'(a_im);
        ext_bre = 33'(b_re);
        ext_bim = 33'(b_im);
        s0_next.op = op_in;
        s0_next.p0 = a_re * m0b;
        s0_next.p1 = a_im * m1b;
        s0_next.p2 = a_re * b_im;
        s0_next.p3 = a_im * b_re;
        s0_next.p4 = b_re * b_re;
        s0_next.p5 = b_im * b_im;
        unique case (op_in)
            OP_ADD:
            begin
                s0_next.sim_re = ext_are + ext_bre;
                s0_next.sim_im = ext_aim + ext_bim;
            end
            OP_SUB:
            begin
                s0_next.sim_re = ext_are - ext_bre;
                s0_next.sim_im = ext_aim - ext_bim;
            end
            OP_CONJ:
            begin
                s0_next.sim_re = ext_are;
                s0_next.sim_im = -ext_aim;
            end
            default:
            begin
                s0_next.sim_re = '0;
                s0_next.sim_im = '0;
            end
        endcase
    end

    logic sat_sre, sat_sim;

    // Stage 1: wide sums and saturation of the simple operations.
    always_comb
    begin
        s1_next.op = s0_reg.op;
        s1_next.s_re = (s0_reg.op == OP_MUL) ? 65'(s0_reg.p0) - 65'(s0_reg.p1)
                                              : 65'(s0_reg.p0) + 65'(s0_reg.p1);
        s1_next.s_im = (s0_reg.op == OP_DIV) ? 65'(s0_reg.p3) - 65'(s0_reg.p2)
                                              : 65'(s0_reg.p3) + 65'(s0_reg.p2);
        s1_next.d = $unsigned(s0_reg.p4) + $unsigned(s0_reg.p5);
        sat_sre = (s0_reg.sim_re > S33_MAX) || (s0_reg.sim_re < S33_MIN);
        sat_sim = (s0_reg.sim_im > S33_MAX) || (s0_reg.sim_im < S33_MIN);
        if (s0_reg.sim_re > S33_MAX)
            s1_next.done_re = POS_MAX;
        else if (s0_reg.sim_re < S33_MIN)
            s1_next.done_re = NEG_MIN;
        else
            s1_next.done_re = s0_reg.sim_re[31:0];
        if (s0_reg.sim_im > S33_MAX)
            s1_next.done_im = POS_MAX;
        else if (s0_reg.sim_im < S33_MIN)
            s1_next.done_im = NEG_MIN;
        else
            s1_next.done_im = s0_reg.sim_im[31:0];
        s1_next.done_sat = sat_sre | sat_sim;
    end

    // Stage 2: sign and magnitude of the sums.
    always_comb
    begin
        s2_next.op       = s1_reg.op;
        s2_next.neg_re   = s1_reg.s_re[64];
        s2_next.neg_im   = s1_reg.s_im[64];
        s2_next.m_re     = s1_reg.s_re[64] ? 64'(-s1_reg.s_re) : s1_reg.s_re[63:0];
        s2_next.m_im     = s1_reg.s_im[64] ? 64'(-s1_reg.s_im) : s1_reg.s_im[63:0];
        s2_next.d        = s1_reg.d;
        s2_next.done_re  = s1_reg.done_re;
        s2_next.done_im  = s1_reg.done_im;
        s2_next.done_sat = s1_reg.done_sat;
    end

    logic [63:0] hi_re, hi_im;
    logic [32:0] pk_re, pk_im;

    // Stage 3: finish the short operations, load divider and root state.
    always_comb
    begin
        hi_re = s2_reg.m_re >> IBITS;
        hi_im = s2_reg.m_im >> IBITS;
        pk_re = pack_mag(s2_reg.neg_re, s2_reg.m_re >> FRAC_BITS);
        pk_im = pack_mag(s2_reg.neg_im, s2_reg.m_im >> FRAC_BITS);
        s3_next.op     = s2_reg.op;
        s3_next.dz     = 1'b0;
        s3_next.sat_re = 1'b0;
        s3_next.sat_im = 1'b0;
        s3_next.neg_re = s2_reg.neg_re;
        s3_next.neg_im = s2_reg.neg_im;
        s3_next.d      = s2_reg.d;
        s3_next.r_re   = '0;
        s3_next.r_im   = '0;
        s3_next.src_re = '0;
        s3_next.src_im = '0;
        s3_next.q_re   = '0;
        s3_next.q_im   = '0;
        unique case (s2_reg.op)
            OP_DIV:
            begin
                s3_next.dz     = (s2_reg.d == 64'd0);
                s3_next.r_re   = hi_re;
                s3_next.r_im   = hi_im;
                s3_next.src_re = s2_reg.m_re << (32 + FRAC_BITS);
                s3_next.src_im = s2_reg.m_im << (32 + FRAC_BITS);
                s3_next.sat_re = (hi_re >= s2_reg.d);
                s3_next.sat_im = (hi_im >= s2_reg.d);
            end
            OP_MAG:
            begin
                s3_next.src_re = s2_reg.m_re;
            end
            OP_MUL:
            begin
                {s3_next.sat_re, s3_next.q_re} = pk_re;
                {s3_next.sat_im, s3_next.q_im} = pk_im;
            end
            OP_SQM:
            begin
                {s3_next.sat_re, s3_next.q_re} = pk_re;
            end
            default:
            begin
                s3_next.q_re   = s2_reg.done_re;
                s3_next.q_im   = s2_reg.done_im;
                s3_next.sat_re = s2_reg.done_sat;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            if (adv[1])
                v_reg[1] <= v_reg[0];
            if (adv[2])
                v_reg[2] <= v_reg[1];
            if (adv[3])
                v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            s0_reg <= s0_next;
        if (adv[1])
            s1_reg <= s1_next;
        if (adv[2])
            s2_reg <= s2_next;
        if (adv[3])
            s3_reg <= s3_next;
    end

    assign v    = v_reg;
    assign dout = s3_reg;

endmodule

[src/cau_step.sv]
// One stage of the shared restoring divider and square root datapath.
module cau_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         v_in,
    input  cau_pkg::it_t din,
    output logic         v_out,
    output cau_pkg::it_t dout
);
    import cau_pkg::*;

    logic        v_reg;
    it_t         stage_reg, stage_next;
    logic        sq;
    logic [64:0] rs_re, t_re, rs_im, t_im;
    logic        ge_re, ge_im;

    // Magnitudes take a root step in the real lane; divisions divide in both lanes.
    always_comb
    begin
        sq    = (din.op == OP_MAG);
        rs_re = sq ? {din.r_re[62:0], din.src_re[63:62]} : {din.r_re, din.src_re[63]};
        t_re  = sq ? {31'd0, din.q_re, 2'b01} : {1'b0, din.d};
        ge_re = (rs_re >= t_re);
        rs_im = {din.r_im, din.src_im[63]};
        t_im  = {1'b0, din.d};
        ge_im = (rs_im >= t_im);
        stage_next = din;
        if ((din.op == OP_DIV) || (din.op == OP_MAG))
        begin
            stage_next.r_re   = ge_re ? 64'(rs_re - t_re) : rs_re[63:0];
            stage_next.src_re = sq ? {din.src_re[61:0], 2'b00} : {din.src_re[62:0], 1'b0};
            stage_next.q_re   = {din.q_re[30:0], ge_re};
            stage_next.r_im   = ge_im ? 64'(rs_im - t_im) : rs_im[63:0];
            stage_next.src_im = {din.src_im[62:0], 1'b0};
            stage_next.q_im   = {din.q_im[30:0], ge_im};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            stage_reg <= stage_next;
    end

    assign v_out = v_reg;
    assign dout  = stage_reg;

endmodule

[src/cau_back.sv]
// Output stage: final saturation, status encoding and the result register.
module cau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               v_in,
    input  cau_pkg::it_t       din,
    output logic               v_out,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic [1:0]         status
);
    import cau_pkg::*;

    logic        v_reg;
    logic [31:0] re_reg, re_next, im_reg, im_next;
    logic [1:0]  st_reg, st_next;
    logic [32:0] pk_re, pk_im;
    logic        sat_re, sat_im;

    always_comb
    begin
        pk_re   = pack_mag(din.neg_re, {32'd0, din.q_re});
        pk_im   = pack_mag(din.neg_im, {32'd0, din.q_im});
        re_next = din.q_re;
        im_next = din.q_im;
        sat_re  = din.sat_re;
        sat_im  = din.sat_im;
        unique case (din.op)
            OP_DIV:
            begin
                if (din.sat_re)
                    re_next = din.neg_re ? NEG_MIN : POS_MAX;
                else
                    {sat_re, re_next} = pk_re;
                if (din.sat_im)
                    im_next = din.neg_im ? NEG_MIN : POS_MAX;
                else
                    {sat_im, im_next} = pk_im;
            end
            OP_MAG:
            begin
                {sat_re, re_next} = pack_mag(1'b0, {32'd0, din.q_re});
                im_next = '0;
                sat_im  = 1'b0;
            end
            default:
            begin
                re_next = din.q_re;
            end
        endcase
        if ((din.op == OP_DIV) && din.dz)
        begin
            re_next = '0;
            im_next = '0;
            st_next = ST_DIVZ;
        end
        else if (sat_re || sat_im)
        begin
            st_next = ST_SAT;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign v_out  = v_reg;
    assign res_re = re_reg;
    assign res_im = im_reg;
    assign status = st_reg;

endmodule

[src/complex_arithmetic_unit_top.sv]
// Top level of the pipelined complex arithmetic unit.
//
// Items enter on the input channel (in_valid, in_ready) with an opcode and two
// complex operands in signed fixed point with FRAC_BITS fraction bits. Each
// item gives exactly one result item on the output channel (out_valid,
// out_ready) with res_re, res_im and a status code, in the order of entry.
// Every item takes the same path of 37 register stages, whatever its opcode:
// four front stages (products, sums, magnitudes, setup), 32 stages of the
// restoring divider and square root (one quotient or root bit per stage),
// and the output register. A new item can be accepted in every cycle unless a
// receiver stall has filled every stage, so throughput is one per cycle.
// Reset clears all valid bits; the pipeline then holds no items.
// When the receiver stalls, the result waits in the output register and each
// stage still moves forward into an empty stage ahead of it, so the pipeline
// fills up its gaps and in_ready only falls once every stage holds an item.
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic signed [31:0] a_re,
    input  logic signed [31:0] a_im,
    input  logic signed [31:0] b_re,
    input  logic signed [31:0] b_im,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic [1:0]         status
);
    import cau_pkg::*;

    // Valid bit and advance enable of every stage, front to back.
    logic [N_STAGES-1:0] v;
    logic [N_STAGES-1:0] adv;

    it_t chain [0:N_STEPS];

    // A stage loads when it is empty or when the stage ahead of it loads.
    for (genvar i = 0; i < N_STAGES - 1; i++)
    begin : g_adv
        assign adv[i] = ~v[i] | adv[i+1];
    end
    assign adv[N_STAGES-1] = ~v[N_STAGES-1] | out_ready;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv[N_FRONT-1:0]),
        .in_valid (in_valid),
        .opcode   (opcode),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .v        (v[N_FRONT-1:0]),
        .dout     (chain[0])
    );

    // One divider or root bit per stage.
    for (genvar g = 0; g < N_STEPS; g++)
    begin : g_step
        cau_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv[N_FRONT+g]),
            .v_in  (v[N_FRONT+g-1]),
            .din   (chain[g]),
            .v_out (v[N_FRONT+g]),
            .dout  (chain[g+1])
        );
    end

    cau_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv[N_STAGES-1]),
        .v_in   (v[N_STAGES-2]),
        .din    (chain[N_STEPS]),
        .v_out  (v[N_STAGES-1]),
        .res_re (res_re),
        .res_im (res_im),
        .status (status)
    );

    assign in_ready  = adv[0];
    assign out_valid = v[N_STAGES-1];

endmodule

[src/cau_checker.sv]
// Port-level checker of the complex arithmetic unit and its bind statement.
`include "complex_arithmetic_unit_top_macros.svh"

module cau_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] res_re,
    input logic signed [31:0] res_im,
    input logic [1:0]         status
);
    import cau_pkg::*;

    // A result that is stalled keeps its value.
    `CAU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im) && $stable(status), "stalled result changed")

    // A divide by zero always returns zero parts.
    `CAU_ASSERT(a_divz_zero, out_valid && (status == ST_DIVZ) |-> (res_re == 32'sd0) && (res_im == 32'sd0), "divide by zero gave nonzero result")

    // An empty output register means the whole pipeline can move, so input is taken.
    `CAU_ASSERT_ALWAYS(a_ready_when_drained, !out_valid |-> in_ready, "input blocked with empty output")

    // A clock edge under reset leaves no result on the output.
    `CAU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);

[sim/complex_arithmetic_unit_top_tb.sv]
// Self-checking testbench of the complex arithmetic unit with a predictor and random flow control.
module complex_arithmetic_unit_top_tb;

    import cau_pkg::*;

    // Fraction bits of the operands; the block is built with its default.
    localparam int FRAC    = FRAC_BITS_DEF;
    // Cycles without any accepted item before the run is declared hung. The
    // longest legal quiet stretch is the forced receiver hold-off plus the
    // pipeline latency, so this leaves a wide margin.
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_LEN    = 300;

    // One result item as the block should return it.
    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  st;
    } cplx_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         opcode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;

    // Results still owed by the block, oldest first.
    cplx_result_t expected_results[$];

    int mismatch_cnt;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_len;
    int quiet_cycles;

    complex_arithmetic_unit_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Clamps an exact value to the 32-bit signed range and notes saturation.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return POS_MAX;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return NEG_MIN;
        end
        return v[31:0];
    endfunction

    // Drops the fraction bits of an exact product, rounding toward zero.
    function automatic logic signed [127:0] trunc_frac(input logic signed [127:0] v);
        if (v < 0)
            return -((-v) >>> FRAC);
        return v >>> FRAC;
    endfunction

    // Quotient n * 2^FRAC / d rounded toward zero; d is positive.
    function automatic logic signed [127:0] frac_quotient(input logic signed [127:0] n,
                                                          input logic signed [127:0] d);
        logic signed [127:0] q;
        if (n < 0)
        begin
            q = ((-n) <<< FRAC) / d;
            return -q;
        end
        q = (n <<< FRAC) / d;
        return q;
    endfunction

    // Floor of the square root of a sum of squares, one root bit at a time.
    function automatic logic signed [127:0] floor_sqrt(input logic signed [127:0] s);
        logic signed [127:0] root;
        logic signed [127:0] cand;
        root = 0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = root | (128'sd1 <<< b);
            if (cand * cand <= s)
                root = cand;
        end
        return root;
    endfunction

    // Works out the one result item that an input item must produce.
    function automatic cplx_result_t predict_complex_op(input op_t op,
                                                        input logic signed [31:0] ar,
                                                        input logic signed [31:0] ai,
                                                        input logic signed [31:0] br,
                                                        input logic signed [31:0] bi);
        cplx_result_t r;
        logic signed [127:0] xr, xi, yr, yi, den;
        logic sat;
        xr  = ar;
        xi  = ai;
        yr  = br;
        yi  = bi;
        sat = 1'b0;
        r.re = '0;
        r.im = '0;
        r.st = ST_OK;
        case (op)
            OP_ADD:
            begin
                r.re = clamp32(xr + yr, sat);
                r.im = clamp32(xi + yi, sat);
            end
            OP_SUB:
            begin
                r.re = clamp32(xr - yr, sat);
                r.im = clamp32(xi - yi, sat);
            end
            OP_MUL:
            begin
                r.re = clamp32(trunc_frac(xr * yr - xi * yi), sat);
                r.im = clamp32(trunc_frac(xr * yi + xi * yr), sat);
            end
            OP_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.st = ST_DIVZ;
                else
                begin
                    r.re = clamp32(frac_quotient(xr * yr + xi * yi, den), sat);
                    r.im = clamp32(frac_quotient(xi * yr - xr * yi, den), sat);
                end
            end
            OP_CONJ:
            begin
                r.re = clamp32(xr, sat);
                r.im = clamp32(-xi, sat);
            end
            OP_MAG:
                r.re = clamp32(floor_sqrt(xr * xr + xi * xi), sat);
            OP_SQM:
                r.re = clamp32(trunc_frac(xr * xr + xi * xi), sat);
            default:
            begin
            end
        endcase
        if (r.st == ST_OK && sat)
            r.st = ST_SAT;
        return r;
    endfunction

    // Offers one item, after random idle cycles, and records what it must
    // produce once the block takes it. Valid is left high on return so that
    // back-to-back items keep it asserted without a glitch.
    task automatic send_complex_item(input op_t op, input logic signed [31:0] ar,
                                     input logic signed [31:0] ai,
                                     input logic signed [31:0] br,
                                     input logic signed [31:0] bi);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        a_re     <= ar;
        a_im     <= ai;
        b_re     <= br;
        b_im     <= bi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_complex_op(op, ar, ai, br, bi));
    endtask

    // Holds the input quiet until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Operand part drawn from a mix of full-range, moderate and corner values,
    // so that both saturated and in-range results are common.
    function automatic logic signed [31:0] random_part();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
            2: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            3:
            begin
                case ($urandom_range(4))
                    0: return 32'sd0;
                    1: return POS_MAX;
                    2: return NEG_MIN;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000;
        endcase
    endfunction

    task automatic send_random_items(input int n);
        logic signed [31:0] bi;
        for (int k = 0; k < n; k++)
        begin
            bi = random_part();
            // Now and then a scalar second operand.
            if ($urandom_range(9) == 0)
                bi = '0;
            send_complex_item(op_t'($urandom_range(7)), random_part(), random_part(),
                              random_part(), bi);
        end
    endtask

    // Corner cases: extremes of every part under every opcode, a zero divisor,
    // conjugation of the most negative imaginary part, scalar operands and the
    // unused opcode.
    task automatic test_directed();
        for (int op = 0; op < 8; op++)
        begin
            send_complex_item(op_t'(op), POS_MAX, NEG_MIN, NEG_MIN, POS_MAX);
            send_complex_item(op_t'(op), 32'sh0100_0000, -32'sh0180_0000,
                              32'sh0080_0000, 32'sh0);
        end
        send_complex_item(OP_DIV, 32'sh0300_0000, 32'sh0100_0000, 32'sh0, 32'sh0);
        send_complex_item(OP_DIV, NEG_MIN, NEG_MIN, 32'sh1, 32'sh0);
        send_complex_item(OP_DIV, 32'sh1, 32'sh0, NEG_MIN, NEG_MIN);
        send_complex_item(OP_CONJ, 32'sh0, NEG_MIN, 32'sh0, 32'sh0);
        send_complex_item(OP_MAG, NEG_MIN, NEG_MIN, 32'sh0, 32'sh0);
        send_complex_item(OP_SQM, NEG_MIN, NEG_MIN, 32'sh0, 32'sh0);
        send_complex_item(OP_MUL, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN);
        send_complex_item(OP_ADD, -32'sh1, -32'sh1, -32'sh1, -32'sh1);
        drain_results();
    endtask

    // Random items under one setting of sender and receiver idling.
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        send_random_items(n);
        drain_results();
    endtask

    // The receiver stops for a long stretch while items keep coming, so every
    // stage fills and in_ready has to fall; then the sender waits for all
    // results before it goes on.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = HOLD_LEN;
        send_random_items(90);
        drain_results();
    endtask

    // Receiver: random stalls, and on request one long hold-off that this
    // process counts itself.
    initial
    begin
        int n;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                n        = hold_len;
                hold_len = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compares every accepted result with the oldest one owed.
    always @(posedge clk)
    begin
        cplx_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result item: re=%h im=%h status=%0d",
                             res_re, res_im, status);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (res_re !== exp_r.re || res_im !== exp_r.im || status !== exp_r.st)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected re=%h im=%h status=%0d, got re=%h im=%h status=%0d",
                                 exp_r.re, exp_r.im, exp_r.st, res_re, res_im, status);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = '0;
        a_re          = '0;
        a_im          = '0;
        b_re          = '0;
        b_im          = '0;
        mismatch_cnt  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 0;
        quiet_cycles  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(25, 52, 340);
        test_random_phase(52, 25, 340);
        test_backpressure();
        test_random_phase(0, 0, 340);

        // Let any stray result show up before the verdict.
        repeat (60) @(posedge clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/cau_pkg.sv
src/cau_front.sv
src/cau_step.sv
src/cau_back.sv
src/complex_arithmetic_unit_top.sv
src/cau_checker.sv
sim/complex_arithmetic_unit_top_tb.sv
